>>> rtl/b64lw_pkg.sv
// Shared types, constants and the symbol table for the base64 line-wrap encoder.
// No dependencies; the front end, queue, emitter, top level and testbench import this package.
`default_nettype none

package b64lw_pkg;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_LINE_LENGTH = 1'b0;

    // Character codes
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;

    // Line length
    localparam logic [7:0] LINE_LEN_RESET = 8'd160;
    localparam logic [7:0] MIN_WRAP_LEN   = 8'd4;

    // Input function codes
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Job queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CHARS_PER_GROUP = 4;
    localparam int unsigned CHAR_IDX_W = $clog2(CHARS_PER_GROUP);
    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = CHAR_IDX_W'(CHARS_PER_GROUP - 1);

    // One unit of work for the emitter: four characters of a group, or a bare column clear
    typedef struct packed {
        logic [CHARS_PER_GROUP-1:0][7:0] chars;
        logic                            has_chars;
        logic                            clear_col;
    } job_t;

    // Emitter phase
    typedef enum logic [1:0] {
        PH_CHAR,
        PH_CR,
        PH_LF
    } phase_t;

    // Six-bit code to base64 alphabet character
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v8 < 8'd26)
            return 8'h41 + v8;
        else if (v8 < 8'd52)
            return 8'h61 + (v8 - 8'd26);
        else if (v8 < 8'd62)
            return 8'h30 + (v8 - 8'd52);
        else if (v8 == 8'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64lw_if.sv
// Valid/ready channel interfaces for the input byte stream and the output characters.
// Depends on nothing; used by the front end, the emitter and the top level.
`default_nettype none

interface b64lw_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface b64lw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/b64lw_front.sv
// Front end: accepts bytes and finish commands, gathers groups, builds emitter jobs.
// Depends on b64lw_pkg and b64lw_in_if.
`default_nettype none

module b64lw_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    b64lw_in_if.sink           in_ch,
    input  wire logic          queue_full,
    output logic               push,
    output b64lw_pkg::job_t    push_job
);
    import b64lw_pkg::*;

    logic [1:0]      held_count_reg, held_count_next;
    logic [1:0][7:0] held_bytes_reg;
    logic            accept;
    logic [7:0]      a_byte, b_byte, c_byte;
    logic [23:0]     word;
    logic            finish;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign finish      = (in_ch.func == FUNC_FINISH);

    // Missing bytes of a partial group read as zero
    assign a_byte = held_bytes_reg[0];
    assign b_byte = (held_count_reg == 2'd1) ? 8'h00 : held_bytes_reg[1];
    assign c_byte = finish ? 8'h00 : in_ch.data_byte;
    assign word   = {a_byte, b_byte, c_byte};

    // Job build
    always_comb
    begin
        push                = accept && (finish || held_count_reg == 2'd2);
        push_job.chars[0]   = sym(word[23:18]);
        push_job.chars[1]   = sym(word[17:12]);
        push_job.chars[2]   = (finish && held_count_reg == 2'd1) ? PAD_CHAR : sym(word[11:6]);
        push_job.chars[3]   = finish ? PAD_CHAR : sym(word[5:0]);
        push_job.has_chars  = (held_count_reg != 2'd0);
        push_job.clear_col  = finish;
    end

    // Group fill count
    always_comb
    begin
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (finish || held_count_reg == 2'd2)
                held_count_next = 2'd0;
            else
                held_count_next = held_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_count_reg <= 2'd0;
        else
            held_count_reg <= held_count_next;
    end

    // Held bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept && !finish && held_count_reg != 2'd2)
            held_bytes_reg[held_count_reg[0]] <= in_ch.data_byte;
    end

endmodule

`default_nettype wire

>>> rtl/b64lw_queue.sv
// Two-entry job queue between the front end and the emitter.
// Depends on b64lw_pkg.
`default_nettype none

module b64lw_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire b64lw_pkg::job_t  push_job,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output b64lw_pkg::job_t       head_job
);
    import b64lw_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

>>> rtl/b64lw_back.sv
// Emitter: sends one char per cycle unless stalled, tracks column, inserts CR LF.
// Depends on b64lw_pkg and b64lw_out_if.
`default_nettype none

module b64lw_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       line_length,
    input  wire logic             job_valid,
    input  wire b64lw_pkg::job_t  job,
    output logic                  pop,
    b64lw_out_if.source           out_ch
);
    import b64lw_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]            col_reg, col_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic                  slot_free;
    logic                  step;
    logic [7:0]            col_inc;
    logic [7:0]            eff_len;
    logic                  wrap;
    logic                  final_char;

    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign step       = job_valid && slot_free;
    assign col_inc    = col_reg + 8'd1;
    assign eff_len    = (line_length < MIN_WRAP_LEN) ? MIN_WRAP_LEN : line_length;
    assign wrap       = (line_length != 8'd0) && (col_inc >= eff_len);
    assign final_char = (idx_reg == LAST_CHAR_IDX);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step && job.has_chars)
        begin
            unique case (phase_reg)
                PH_CHAR: phase_next = wrap ? PH_CR : PH_CHAR;
                PH_CR:   phase_next = PH_LF;
                PH_LF:   phase_next = PH_CHAR;
                default: phase_next = PH_CHAR;
            endcase
        end
    end

    // Emit, column and index update
    always_comb
    begin
        pop            = 1'b0;
        idx_next       = idx_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            if (!job.has_chars)
            begin
                // Finish with nothing held: only the column clears
                pop      = 1'b1;
                col_next = 8'd0;
            end
            else
            begin
                out_valid_next = 1'b1;
                unique case (phase_reg)
                    PH_CHAR:
                    begin
                        out_char_next = job.chars[idx_reg];
                        out_last_next = final_char && !wrap;
                        if (wrap)
                            col_next = 8'd0;
                        else
                        begin
                            col_next = col_inc;
                            if (final_char)
                            begin
                                pop      = 1'b1;
                                idx_next = '0;
                                if (job.clear_col)
                                    col_next = 8'd0;
                            end
                            else
                                idx_next = idx_reg + 1'b1;
                        end
                    end
                    PH_CR:
                    begin
                        out_char_next = CR_CHAR;
                        out_last_next = 1'b0;
                    end
                    PH_LF:
                    begin
                        out_char_next = LF_CHAR;
                        out_last_next = final_char;
                        if (final_char)
                        begin
                            pop      = 1'b1;
                            idx_next = '0;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                    default:
                    begin
                        out_char_next = CR_CHAR;
                        out_last_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHAR;
            idx_reg       <= '0;
            col_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.last     = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/base64_stream_encoder_line_wrap_top.sv
// Streaming base64 encoder with CR LF line wrapping. Each input transfer carries
// a data byte or a finish command; every third byte yields four characters and a
// finish flushes a partial group with '=' padding and clears the column. The input
// accepts one transfer per cycle while the two-entry job queue has room; the emitter
// sends one character per cycle while the output is ready and a job is waiting; four
// characters go out per three bytes, plus two for each CR LF, so the output port
// sets the sustained rate. A group's job is registered in the job queue and its
// characters in the output register. No clearing pass after reset.
// Depends on b64lw_pkg, b64lw_if, b64lw_front, b64lw_queue and b64lw_back.
`default_nettype none

module base64_stream_encoder_line_wrap_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    b64lw_in_if.sink                               in_ch,
    b64lw_out_if.source                            out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [b64lw_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [b64lw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [b64lw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import b64lw_pkg::*;

    logic [7:0] line_length_reg;
    logic       cfg_write;
    logic       fq_push;
    job_t       fq_push_job;
    logic       fq_pop;
    logic       fq_full;
    logic       fq_head_valid;
    job_t       fq_head_job;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LENGTH);
    assign prdata    = (paddr[2] == REG_LINE_LENGTH) ?
                       {{(APB_DATA_W-8){1'b0}}, line_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_length_reg <= LINE_LEN_RESET;
        else if (cfg_write)
            line_length_reg <= pwdata[7:0];
    end

    // Front end
    b64lw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (fq_full),
        .push       (fq_push),
        .push_job   (fq_push_job)
    );

    // Job queue
    b64lw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fq_push),
        .push_job   (fq_push_job),
        .pop        (fq_pop),
        .full       (fq_full),
        .head_valid (fq_head_valid),
        .head_job   (fq_head_job)
    );

    // Emitter
    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_length (line_length_reg),
        .job_valid   (fq_head_valid),
        .job         (fq_head_job),
        .pop         (fq_pop),
        .out_ch      (out_ch)
    );

`ifndef SYNTH
    // Queue never takes a job while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fq_push && fq_full))
        else $error("job queue overflow");

    // A transferred CR is followed by LF in the next output slot
    a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.out_char == CR_CHAR)
        |=> (out_ch.valid && out_ch.out_char == LF_CHAR))
        else $error("CR not followed by LF");

    // CR never closes a run
    a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.out_char == CR_CHAR) |-> !out_ch.last)
        else $error("last flag on CR");
`endif

endmodule

`default_nettype wire

>>> tb/tb_base64_stream_encoder_line_wrap_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the base64 line-wrap encoder: directed and random byte streams,
// line-length changes over APB, random stalls on both channels, char-by-char compare.
// Depends on b64lw_pkg, b64lw_if and base64_stream_encoder_line_wrap_top.

module tb_base64_stream_encoder_line_wrap_top;
    import b64lw_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LINE_LEN_ADDR = APB_ADDR_W'(4 * REG_LINE_LENGTH);

    // One input transfer and one expected output character
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } enc_input_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    b64lw_in_if  in_ch ();
    b64lw_out_if out_ch ();

    base64_stream_encoder_line_wrap_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Encoder state as the testbench sees it
    logic [7:0] line_len_model = LINE_LEN_RESET;
    logic [7:0] held_model [2];
    logic [1:0] held_cnt_model = 2'd0;
    logic [7:0] column_model = 8'd0;

    enc_input_t queued_items [$];
    enc_char_t  expected_chars [$];
    enc_char_t  item_chars [$];

    int unsigned mismatch_count = 0;
    int unsigned items_accepted = 0;
    int unsigned finish_count = 0;
    int unsigned chars_checked = 0;
    int unsigned crlf_count = 0;
    int unsigned settings_used = 1;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned in_calm = 0;
    int unsigned out_calm = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pause length: mostly none or short, a few long, with pause-free stretches
    function automatic int unsigned pick_pause(inout int unsigned calm_left);
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 4)
        begin
            calm_left = $urandom_range(40, 10);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(25, 6);
    endfunction

    // Base64 alphabet lookup
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + 8'(v);
        else if (v < 6'd52)
            return 8'h61 + 8'(v - 6'd26);
        else if (v < 6'd62)
            return 8'h30 + 8'(v - 6'd52);
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    // Emit one character and the CR LF that may follow it
    task automatic put_char(input logic [7:0] ch);
        logic [7:0] wrap_at;
        item_chars.push_back('{ch, 1'b0});
        column_model++;
        if (line_len_model != 8'd0)
        begin
            wrap_at = (line_len_model < MIN_WRAP_LEN) ? MIN_WRAP_LEN : line_len_model;
            if (column_model >= wrap_at)
            begin
                item_chars.push_back('{CR_CHAR, 1'b0});
                item_chars.push_back('{LF_CHAR, 1'b0});
                column_model = 8'd0;
                crlf_count++;
            end
        end
    endtask

    // Expected characters for one accepted input transfer
    task automatic encode_item(input logic func, input logic [7:0] data_in);
        logic [7:0] a;
        logic [7:0] b;
        int n;
        item_chars.delete();
        a = held_model[0];
        b = held_model[1];
        if (func == FUNC_DATA)
        begin
            if (held_cnt_model < 2'd2)
            begin
                held_model[held_cnt_model[0]] = data_in;
                held_cnt_model++;
            end
            else
            begin
                put_char(b64_symbol(a[7:2]));
                put_char(b64_symbol({a[1:0], b[7:4]}));
                put_char(b64_symbol({b[3:0], data_in[7:6]}));
                put_char(b64_symbol(data_in[5:0]));
                held_cnt_model = 2'd0;
            end
        end
        else
        begin
            finish_count++;
            if (held_cnt_model == 2'd1)
            begin
                put_char(b64_symbol(a[7:2]));
                put_char(b64_symbol({a[1:0], 4'b0000}));
                put_char(PAD_CHAR);
                put_char(PAD_CHAR);
            end
            else if (held_cnt_model >= 2'd2)
            begin
                put_char(b64_symbol(a[7:2]));
                put_char(b64_symbol({a[1:0], b[7:4]}));
                put_char(b64_symbol({b[3:0], 2'b00}));
                put_char(PAD_CHAR);
            end
            held_cnt_model = 2'd0;
            column_model = 8'd0;
        end
        n = item_chars.size();
        for (int i = 0; i < n; i++)
            expected_chars.push_back('{item_chars[i].ch, (i == n - 1)});
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s at char %0d: expected 0x%0h, got 0x%0h",
                     what, chars_checked, want, got);
    endtask

    // Input driver: holds a transfer until accepted, then predicts it
    always @(posedge clk)
    begin : drive_input
        enc_input_t item;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
            begin
                encode_item(in_ch.func, in_ch.data_byte);
                items_accepted++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (queued_items.size() > 0)
            begin
                item = queued_items.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.func      <= item.func;
                in_ch.data_byte <= item.data_byte;
                gap_left = pick_pause(in_calm);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Output monitor: random ready, compare each transfer with the oldest expectation
    always @(posedge clk)
    begin : watch_output
        enc_char_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("MISMATCH: unexpected char 0x%0h (last %0b), none expected",
                                 out_ch.out_char, out_ch.last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_char !== want.ch)
                        report_mismatch("out_char", want.ch, out_ch.out_char);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", want.last, out_ch.last);
                    chars_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = pick_pause(out_calm);
            end
        end
    end

    // One APB transfer: setup, access, wait for pready
    task automatic apb_access(input logic is_write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= LINE_LEN_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the line length, then read it back
    task automatic set_line_length(input logic [7:0] len);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b1, APB_DATA_W'(len), rdata);
        line_len_model = len;
        settings_used++;
        apb_access(1'b0, '0, rdata);
        if (rdata[7:0] !== len)
            report_mismatch("line_length readback", len, rdata[7:0]);
    endtask

    task automatic queue_item(input logic func, input logic [7:0] data_in);
        queued_items.push_back('{func, data_in});
    endtask

    // Random messages: short runs of bytes, mostly closed by a finish
    task automatic queue_messages(input int unsigned budget);
        int unsigned made;
        int unsigned len;
        made = 0;
        while (made < budget)
        begin
            len = ($urandom_range(99, 0) < 85) ? $urandom_range(8, 0) : $urandom_range(40, 9);
            for (int unsigned k = 0; k < len; k++)
                queue_item(FUNC_DATA, 8'($urandom));
            made += len;
            if ($urandom_range(9, 0) != 0)
            begin
                queue_item(FUNC_FINISH, 8'($urandom));
                made++;
            end
        end
    endtask

    // Wait for all transfers and results, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_items.size() != 0 || in_ch.valid || expected_chars.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_DATA;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty finish, extreme bytes, '+' and '/', both padding forms
        queue_item(FUNC_FINISH, 8'h00);
        queue_item(FUNC_DATA, 8'h00);
        queue_item(FUNC_DATA, 8'h00);
        queue_item(FUNC_DATA, 8'h00);
        queue_item(FUNC_DATA, 8'hFF);
        queue_item(FUNC_DATA, 8'hFF);
        queue_item(FUNC_DATA, 8'hFF);
        queue_item(FUNC_DATA, 8'hFB);
        queue_item(FUNC_DATA, 8'hEF);
        queue_item(FUNC_DATA, 8'hBE);
        queue_item(FUNC_DATA, 8'h4D);
        queue_item(FUNC_FINISH, 8'hFF);
        queue_item(FUNC_DATA, 8'h4D);
        queue_item(FUNC_DATA, 8'h61);
        queue_item(FUNC_FINISH, 8'h00);
        queue_item(FUNC_FINISH, 8'hA5);
        queue_item(FUNC_DATA, 8'h80);
        queue_item(FUNC_DATA, 8'h01);
        queue_item(FUNC_DATA, 8'h7F);
        queue_item(FUNC_FINISH, 8'h5A);
        wait_idle();

        // Open line at column 12, then lower the length below it
        for (int i = 0; i < 9; i++)
            queue_item(FUNC_DATA, 8'($urandom));
        wait_idle();
        set_line_length(8'd10);
        queue_messages(12);
        wait_idle();

        // No wrapping over a long line, then wrap at 8 from a column far past it
        set_line_length(8'd0);
        queue_item(FUNC_FINISH, 8'($urandom));
        for (int i = 0; i < 60; i++)
            queue_item(FUNC_DATA, 8'($urandom));
        wait_idle();
        set_line_length(8'd8);
        queue_messages(12);
        wait_idle();

        // Short lengths act as four; then the widest setting and a random one
        set_line_length(8'd1);
        queue_messages(12);
        wait_idle();
        set_line_length(8'd2);
        queue_messages(12);
        wait_idle();
        set_line_length(8'd3);
        queue_messages(12);
        wait_idle();
        set_line_length(8'd4);
        queue_messages(12);
        wait_idle();
        set_line_length(8'd255);
        queue_messages(12);
        wait_idle();
        set_line_length(8'($urandom_range(120, 5)));
        queue_messages(12);
        wait_idle();

        repeat (20) @(posedge clk);
        $display("Run covered %0d input transfers (%0d finish), %0d characters checked,",
                 items_accepted, finish_count, chars_checked);
        $display("%0d line breaks, %0d line-length settings", crlf_count, settings_used);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d characters still expected", expected_chars.size());
        $display("Verification failed");
        $finish;
    end

endmodule

>>> base64_stream_encoder_line_wrap_top.f
rtl/b64lw_pkg.sv
rtl/b64lw_if.sv
rtl/b64lw_front.sv
rtl/b64lw_queue.sv
rtl/b64lw_back.sv
rtl/base64_stream_encoder_line_wrap_top.sv
tb/tb_base64_stream_encoder_line_wrap_top.sv
